[src/rxpost_pkg.sv]
// Shared types, constants and helper functions for the regex infix-to-postfix converter.
package rxpost_pkg;

  localparam int CHAR_W          = 8;
  localparam int CODE_W          = 3;
  localparam int EPOS_W          = 16;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int POS_WIDTH_DEF   = 16;
  localparam int MAX_RESULTS     = 40;
  localparam int RCNT_W          = $clog2(MAX_RESULTS + 1);
  localparam int CFG_AW          = 2;
  localparam int OUT_PAY_W       = CHAR_W + CODE_W + EPOS_W;
  localparam int OUT_TDATA_W     = ((OUT_PAY_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] OPEN_CH     = 8'h28;
  localparam logic [CHAR_W-1:0] CLOSE_CH    = 8'h29;
  localparam logic [CHAR_W-1:0] CLOSURE_RST = 8'd42;
  localparam logic [CHAR_W-1:0] UNION_RST   = 8'd124;
  localparam logic [CHAR_W-1:0] CONCAT_RST  = 8'd46;

  localparam logic [CFG_AW-1:0] REG_CLOSURE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_UNION   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CONCAT  = 2'd2;

  localparam logic [CODE_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [CODE_W-1:0] ERR_FIRST       = 3'd1;
  localparam logic [CODE_W-1:0] ERR_BIN_BIN     = 3'd2;
  localparam logic [CODE_W-1:0] ERR_BIN_CLOSURE = 3'd3;
  localparam logic [CODE_W-1:0] ERR_BIN_CLOSE   = 3'd4;
  localparam logic [CODE_W-1:0] ERR_BIN_END     = 3'd5;
  localparam logic [CODE_W-1:0] ERR_UNMATCHED   = 3'd6;
  localparam logic [CODE_W-1:0] ERR_OVERFLOW    = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0] closure_ch;
    logic [CHAR_W-1:0] uni_ch;
    logic [CHAR_W-1:0] concat_ch;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has_ch;
    logic              last;
    logic [CODE_W-1:0] code;
    logic [EPOS_W-1:0] epos;
  } res_t;

  typedef enum logic [2:0] {
    OB_NONE,
    OB_PUSH,
    OB_REPLACE,
    OB_MARK_LAST,
    OB_FLUSH
  } ob_op_t;

  typedef struct packed {
    ob_op_t op;
    res_t   res;
  } ob_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic pend_v;
  } ob_st_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEXT,
    ST_FEED,
    ST_PROC,
    ST_RD,
    ST_CMP,
    ST_LEND,
    ST_PUSH,
    ST_ERR,
    ST_END,
    ST_FLUSH
  } st_t;

  typedef enum logic [1:0] {
    PH_H,
    PH_CAT,
    PH_C,
    PH_FIN
  } phase_t;

  typedef enum logic [1:0] {
    LP_OP,
    LP_CLOSE,
    LP_FIN
  } loop_t;

  function automatic logic is_bin(cfg_t c, logic [CHAR_W-1:0] x);
    return (x == c.uni_ch) || (x == c.concat_ch);
  endfunction

  function automatic logic is_op(cfg_t c, logic [CHAR_W-1:0] x);
    return is_bin(c, x) || (x == c.closure_ch);
  endfunction

endpackage

[src/rxpost_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rxpost_ram #(
  parameter int WIDTH = rxpost_pkg::CHAR_W,
  parameter int DEPTH = rxpost_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/rxpost_obuf.sv]
// Result hold-back register and output register of the result stream.
module rxpost_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  rxpost_pkg::ob_cmd_t cmd,
  output rxpost_pkg::ob_st_t  st,
  output logic                out_valid,
  input  logic                out_ready,
  output rxpost_pkg::res_t    out_res
);

  logic             pend_v_r, pend_v_nxt;
  rxpost_pkg::res_t pend_r, pend_nxt;
  logic             out_v_r, out_v_nxt;
  rxpost_pkg::res_t out_r, out_nxt;
  logic             out_free;
  logic             move;

  assign out_free = !out_v_r || out_ready;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    move       = 1'b0;
    unique case (cmd.op)
      rxpost_pkg::OB_PUSH: begin
        move       = pend_v_r;
        pend_nxt   = cmd.res;
        pend_v_nxt = 1'b1;
      end
      rxpost_pkg::OB_REPLACE: begin
        pend_nxt   = cmd.res;
        pend_v_nxt = 1'b1;
      end
      rxpost_pkg::OB_MARK_LAST: begin
        pend_nxt.last = 1'b1;
      end
      rxpost_pkg::OB_FLUSH: begin
        if (pend_v_r && out_free) begin
          move       = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    out_v_nxt = move ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
    out_nxt   = move ? pend_r : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign st.push_ok = !pend_v_r || out_free;
  assign st.pend_v  = pend_v_r;
  assign out_valid  = out_v_r;
  assign out_res    = out_r;

endmodule

[src/rxpost_core.sv]
// Sequencer for concat insertion and shunting-yard conversion over the operator stack.
module rxpost_core #(
  parameter int STACK_DEPTH = rxpost_pkg::STACK_DEPTH_DEF,
  parameter int POS_WIDTH   = rxpost_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rxpost_pkg::cfg_t                cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rxpost_pkg::CHAR_W-1:0]   in_ch,
  input  logic                            in_last,
  output logic                            ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]  ram_waddr,
  output logic [rxpost_pkg::CHAR_W-1:0]   ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(STACK_DEPTH)-1:0]  ram_raddr,
  input  logic [rxpost_pkg::CHAR_W-1:0]   ram_rdata,
  output rxpost_pkg::ob_cmd_t             ob_cmd,
  input  rxpost_pkg::ob_st_t              ob_st
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int RW = rxpost_pkg::RCNT_W;
  localparam int DW = rxpost_pkg::CHAR_W;

  rxpost_pkg::st_t    state_r, state_nxt;
  rxpost_pkg::phase_t phase_r, phase_nxt;
  rxpost_pkg::loop_t  loop_r, loop_nxt;

  logic          hraw_v_r, hraw_v_nxt;
  logic [DW-1:0] hraw_r, hraw_nxt;
  logic          htok_v_r, htok_v_nxt;
  logic [DW-1:0] htok_r, htok_nxt;
  logic [DW-1:0] ptok_r, ptok_nxt;
  logic [DW-1:0] la_r, la_nxt;
  logic          la_end_r, la_end_nxt;
  logic [DW-1:0] cur_c_r, cur_c_nxt;
  logic          cur_last_r, cur_last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic          disc_r, disc_nxt;
  logic [RW-1:0] rcnt_r, rcnt_nxt;
  logic [rxpost_pkg::CODE_W-1:0] err_r, err_nxt;

  logic [DW-1:0] ft;
  logic [CW-1:0] cnt_m1;
  logic          cnt_zero, cnt_full, rcnt_full, emit_ok, cat_ok;
  logic          in_fire, pop_cond, ptok_plain;
  logic [rxpost_pkg::CODE_W-1:0] proc_err;
  logic [31:0]   pos_ext;
  rxpost_pkg::res_t emit_res;

  assign in_ready  = (state_r == rxpost_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_zero  = (cnt_r == '0);
  assign cnt_full  = (cnt_r == CW'(STACK_DEPTH));
  assign rcnt_full = (rcnt_r >= RW'(rxpost_pkg::MAX_RESULTS));
  assign emit_ok   = rcnt_full || ob_st.push_ok;
  assign pos_ext   = 32'(pos_r);

  assign ram_raddr = cnt_m1[AW-1:0];
  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_wdata = ptok_r;

  always_comb begin
    unique case (phase_r)
      rxpost_pkg::PH_H:   ft = hraw_r;
      rxpost_pkg::PH_CAT: ft = cfg.concat_ch;
      default:            ft = cur_c_r;
    endcase
  end

  assign cat_ok = (hraw_r != rxpost_pkg::OPEN_CH) && (hraw_r != cfg.uni_ch) &&
                  !((cur_c_r == cfg.closure_ch) || (cur_c_r == cfg.uni_ch) ||
                    (cur_c_r == rxpost_pkg::CLOSE_CH));

  always_comb begin
    proc_err = rxpost_pkg::ERR_NONE;
    if (rxpost_pkg::is_bin(cfg, ptok_r)) begin
      if (la_end_r) begin
        proc_err = rxpost_pkg::ERR_BIN_END;
      end else if (rxpost_pkg::is_bin(cfg, la_r)) begin
        proc_err = rxpost_pkg::ERR_BIN_BIN;
      end else if (la_r == cfg.closure_ch) begin
        proc_err = rxpost_pkg::ERR_BIN_CLOSURE;
      end else if (la_r == rxpost_pkg::CLOSE_CH) begin
        proc_err = rxpost_pkg::ERR_BIN_CLOSE;
      end
    end
  end

  assign ptok_plain = !rxpost_pkg::is_op(cfg, ptok_r) && (ptok_r != rxpost_pkg::OPEN_CH) &&
                      (ptok_r != rxpost_pkg::CLOSE_CH);

  // Shared compare unit: stacked operator against the incoming token.
  assign pop_cond = (loop_r == rxpost_pkg::LP_FIN) ||
                    ((ram_rdata != rxpost_pkg::OPEN_CH) &&
                     ((loop_r != rxpost_pkg::LP_OP) || (ram_rdata <= ptok_r)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rxpost_pkg::ST_IDLE: begin
        if (in_fire && !disc_r) begin
          state_nxt = hraw_v_r ? rxpost_pkg::ST_FEED : rxpost_pkg::ST_NEXT;
        end
      end
      rxpost_pkg::ST_NEXT: begin
        unique case (phase_r)
          rxpost_pkg::PH_H:
            state_nxt = (cat_ok || cur_last_r) ? rxpost_pkg::ST_FEED : rxpost_pkg::ST_FLUSH;
          rxpost_pkg::PH_CAT:
            state_nxt = cur_last_r ? rxpost_pkg::ST_FEED : rxpost_pkg::ST_FLUSH;
          rxpost_pkg::PH_C:
            state_nxt = htok_v_r ? rxpost_pkg::ST_PROC : rxpost_pkg::ST_RD;
          default:
            state_nxt = rxpost_pkg::ST_RD;
        endcase
      end
      rxpost_pkg::ST_FEED: begin
        if (!htok_v_r) begin
          state_nxt = rxpost_pkg::is_op(cfg, ft) ? rxpost_pkg::ST_ERR : rxpost_pkg::ST_NEXT;
        end else begin
          state_nxt = rxpost_pkg::ST_PROC;
        end
      end
      rxpost_pkg::ST_PROC: begin
        if (proc_err != rxpost_pkg::ERR_NONE) begin
          state_nxt = rxpost_pkg::ST_ERR;
        end else if ((ptok_r == rxpost_pkg::OPEN_CH) && !rxpost_pkg::is_op(cfg, ptok_r)) begin
          state_nxt = rxpost_pkg::ST_PUSH;
        end else if (!ptok_plain) begin
          state_nxt = rxpost_pkg::ST_RD;
        end else if (emit_ok) begin
          state_nxt = rxpost_pkg::ST_NEXT;
        end
      end
      rxpost_pkg::ST_RD: begin
        state_nxt = cnt_zero ? rxpost_pkg::ST_LEND : rxpost_pkg::ST_CMP;
      end
      rxpost_pkg::ST_CMP: begin
        if (!pop_cond) begin
          state_nxt = rxpost_pkg::ST_LEND;
        end else if (emit_ok) begin
          state_nxt = rxpost_pkg::ST_RD;
        end
      end
      rxpost_pkg::ST_LEND: begin
        unique case (loop_r)
          rxpost_pkg::LP_OP:    state_nxt = rxpost_pkg::ST_PUSH;
          rxpost_pkg::LP_CLOSE:
            state_nxt = cnt_zero ? rxpost_pkg::ST_ERR : rxpost_pkg::ST_NEXT;
          default:              state_nxt = rxpost_pkg::ST_END;
        endcase
      end
      rxpost_pkg::ST_PUSH: begin
        state_nxt = cnt_full ? rxpost_pkg::ST_ERR : rxpost_pkg::ST_NEXT;
      end
      rxpost_pkg::ST_ERR: begin
        if (emit_ok) begin
          state_nxt = rxpost_pkg::ST_FLUSH;
        end
      end
      rxpost_pkg::ST_END: begin
        state_nxt = rxpost_pkg::ST_FLUSH;
      end
      rxpost_pkg::ST_FLUSH: begin
        if (ob_st.push_ok) begin
          state_nxt = rxpost_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rxpost_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    loop_nxt     = loop_r;
    hraw_v_nxt   = hraw_v_r;
    hraw_nxt     = hraw_r;
    htok_v_nxt   = htok_v_r;
    htok_nxt     = htok_r;
    ptok_nxt     = ptok_r;
    la_nxt       = la_r;
    la_end_nxt   = la_end_r;
    cur_c_nxt    = cur_c_r;
    cur_last_nxt = cur_last_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    disc_nxt     = disc_r;
    rcnt_nxt     = rcnt_r;
    err_nxt      = err_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    emit_res.ch     = ptok_r;
    emit_res.has_ch = 1'b1;
    emit_res.last   = 1'b0;
    emit_res.code   = rxpost_pkg::ERR_NONE;
    emit_res.epos   = '0;
    ob_cmd.op       = rxpost_pkg::OB_NONE;

    unique case (state_r)
      rxpost_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (disc_r) begin
            if (in_last) begin
              disc_nxt = 1'b0;
            end
          end else begin
            cur_c_nxt    = in_ch;
            cur_last_nxt = in_last;
            rcnt_nxt     = '0;
            phase_nxt    = hraw_v_r ? rxpost_pkg::PH_H : rxpost_pkg::PH_CAT;
          end
        end
      end
      rxpost_pkg::ST_NEXT: begin
        unique case (phase_r)
          rxpost_pkg::PH_H, rxpost_pkg::PH_CAT: begin
            if ((phase_r == rxpost_pkg::PH_H) && cat_ok) begin
              phase_nxt = rxpost_pkg::PH_CAT;
            end else if (cur_last_r) begin
              phase_nxt  = rxpost_pkg::PH_C;
              hraw_v_nxt = 1'b0;
            end else begin
              hraw_v_nxt = 1'b1;
              hraw_nxt   = cur_c_r;
            end
          end
          rxpost_pkg::PH_C: begin
            phase_nxt = rxpost_pkg::PH_FIN;
            if (htok_v_r) begin
              ptok_nxt   = htok_r;
              la_end_nxt = 1'b1;
              htok_v_nxt = 1'b0;
            end else begin
              loop_nxt = rxpost_pkg::LP_FIN;
            end
          end
          default: loop_nxt = rxpost_pkg::LP_FIN;
        endcase
      end
      rxpost_pkg::ST_FEED: begin
        if (!htok_v_r) begin
          if (rxpost_pkg::is_op(cfg, ft)) begin
            err_nxt = rxpost_pkg::ERR_FIRST;
          end else begin
            htok_v_nxt = 1'b1;
            htok_nxt   = ft;
          end
        end else begin
          ptok_nxt   = htok_r;
          la_nxt     = ft;
          la_end_nxt = 1'b0;
          htok_nxt   = ft;
        end
      end
      rxpost_pkg::ST_PROC: begin
        if (!(ptok_plain && !emit_ok && (proc_err == rxpost_pkg::ERR_NONE))) begin
          pos_nxt = pos_r + POS_WIDTH'(1);
        end
        if (proc_err != rxpost_pkg::ERR_NONE) begin
          err_nxt = proc_err;
        end else if (rxpost_pkg::is_op(cfg, ptok_r)) begin
          loop_nxt = rxpost_pkg::LP_OP;
        end else if (ptok_r == rxpost_pkg::CLOSE_CH) begin
          loop_nxt = rxpost_pkg::LP_CLOSE;
        end else if (ptok_plain && !rcnt_full && ob_st.push_ok) begin
          ob_cmd.op = rxpost_pkg::OB_PUSH;
          rcnt_nxt  = rcnt_r + RW'(1);
        end
      end
      rxpost_pkg::ST_RD: begin
        ram_re = !cnt_zero;
      end
      rxpost_pkg::ST_CMP: begin
        emit_res.ch = ram_rdata;
        if (pop_cond && emit_ok) begin
          cnt_nxt = cnt_m1;
          if (!rcnt_full) begin
            ob_cmd.op = rxpost_pkg::OB_PUSH;
            rcnt_nxt  = rcnt_r + RW'(1);
          end
        end
      end
      rxpost_pkg::ST_LEND: begin
        if (loop_r == rxpost_pkg::LP_CLOSE) begin
          if (cnt_zero) begin
            err_nxt = rxpost_pkg::ERR_UNMATCHED;
          end else begin
            cnt_nxt = cnt_m1;
          end
        end
      end
      rxpost_pkg::ST_PUSH: begin
        if (cnt_full) begin
          err_nxt = rxpost_pkg::ERR_OVERFLOW;
        end else begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      rxpost_pkg::ST_ERR: begin
        emit_res.ch     = '0;
        emit_res.has_ch = 1'b0;
        emit_res.last   = 1'b1;
        emit_res.code   = err_r;
        emit_res.epos   = (err_r == rxpost_pkg::ERR_UNMATCHED) ?
                          pos_ext[rxpost_pkg::EPOS_W-1:0] : '0;
        if (emit_ok) begin
          ob_cmd.op  = rcnt_full ? rxpost_pkg::OB_REPLACE : rxpost_pkg::OB_PUSH;
          hraw_v_nxt = 1'b0;
          htok_v_nxt = 1'b0;
          cnt_nxt    = '0;
          pos_nxt    = '0;
          disc_nxt   = !cur_last_r;
        end
      end
      rxpost_pkg::ST_END: begin
        emit_res.ch     = '0;
        emit_res.has_ch = 1'b0;
        emit_res.last   = 1'b1;
        ob_cmd.op  = ob_st.pend_v ? rxpost_pkg::OB_MARK_LAST : rxpost_pkg::OB_PUSH;
        hraw_v_nxt = 1'b0;
        htok_v_nxt = 1'b0;
        cnt_nxt    = '0;
        pos_nxt    = '0;
        disc_nxt   = 1'b0;
      end
      rxpost_pkg::ST_FLUSH: begin
        ob_cmd.op = rxpost_pkg::OB_FLUSH;
      end
      default: ;
    endcase
    ob_cmd.res = emit_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rxpost_pkg::ST_IDLE;
      phase_r  <= rxpost_pkg::PH_H;
      loop_r   <= rxpost_pkg::LP_OP;
      hraw_v_r <= 1'b0;
      htok_v_r <= 1'b0;
      cnt_r    <= '0;
      pos_r    <= '0;
      disc_r   <= 1'b0;
      rcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      loop_r   <= loop_nxt;
      hraw_v_r <= hraw_v_nxt;
      htok_v_r <= htok_v_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      disc_r   <= disc_nxt;
      rcnt_r   <= rcnt_nxt;
    end
    hraw_r     <= hraw_nxt;
    htok_r     <= htok_nxt;
    ptok_r     <= ptok_nxt;
    la_r       <= la_nxt;
    la_end_r   <= la_end_nxt;
    cur_c_r    <= cur_c_nxt;
    cur_last_r <= cur_last_nxt;
    err_r      <= err_nxt;
  end

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ob_st.pend_v)
    else $error("held-back result still pending while ready");

  a_push_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cmd.op == rxpost_pkg::OB_PUSH) |-> ob_st.push_ok)
    else $error("result request issued while the output path is blocked");

  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (!hraw_v_r && !htok_v_r && (cnt_r == '0)))
    else $error("expression state not cleared while discarding");

  a_full_push_err: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rxpost_pkg::ST_PUSH) && cnt_full) |=> (state_r == rxpost_pkg::ST_ERR))
    else $error("push onto a full stack did not raise an error");
`endif

endmodule

[src/regex_infix_to_postfix_top.sv]
// Top level of the regex infix-to-postfix converter: stream ports, configuration, stack RAM.
// After a request is accepted the block is busy; each operator popped from the stack is a read of
// the stack RAM with registered read data followed by a compare in the shared compare unit, and
// each compare that ends a pop loop is a step of its own. A discarded character is taken in the
// idle state. Stalls on the result stream add to the busy time.
// Synchronous active-low reset restores the operator codes and clears the expression state.
module regex_infix_to_postfix_top #(
  parameter int STACK_DEPTH = rxpost_pkg::STACK_DEPTH_DEF,
  parameter int POS_WIDTH   = rxpost_pkg::POS_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rxpost_pkg::CHAR_W-1:0]      in_tdata,   // in_char
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rxpost_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_char, error_code, error_pos
  output logic                               out_tuser,  // has_char
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [rxpost_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [rxpost_pkg::CHAR_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(STACK_DEPTH);

  rxpost_pkg::cfg_t    cfg_r, cfg_nxt;
  rxpost_pkg::ob_cmd_t ob_cmd;
  rxpost_pkg::ob_st_t  ob_st;
  rxpost_pkg::res_t    out_res;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [rxpost_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        rxpost_pkg::REG_CLOSURE: cfg_nxt.closure_ch = cfg_wdata;
        rxpost_pkg::REG_UNION:   cfg_nxt.uni_ch     = cfg_wdata;
        rxpost_pkg::REG_CONCAT:  cfg_nxt.concat_ch  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.closure_ch <= rxpost_pkg::CLOSURE_RST;
      cfg_r.uni_ch     <= rxpost_pkg::UNION_RST;
      cfg_r.concat_ch  <= rxpost_pkg::CONCAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rxpost_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_WIDTH   (POS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tdata),
    .in_last   (in_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ob_cmd    (ob_cmd),
    .ob_st     (ob_st)
  );

  rxpost_ram #(
    .WIDTH (rxpost_pkg::CHAR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rxpost_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ob_cmd),
    .st        (ob_st),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(rxpost_pkg::OUT_TDATA_W - rxpost_pkg::OUT_PAY_W){1'b0}},
                      out_res.epos, out_res.code, out_res.ch};
  assign out_tuser = out_res.has_ch;
  assign out_tlast = out_res.last;

endmodule
